// ===== rtl/pns_pkg.sv =====
// ----------------------------------------------------------------------------
// pns_pkg: shared types and constants of the point store nearest search
// Widths, command and status codes, the stored point word and the scan tag.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

   localparam int COORD_W   = 28;                      // input coordinates
   localparam int FRAC_W    = 4;                       // fractional bits
   localparam int UNIT_W    = COORD_W - FRAC_W;        // stored whole-unit x, y
   localparam int TOL_W     = 16;
   localparam int CAPACITY  = 4096;
   localparam int INDEX_W   = $clog2(CAPACITY);
   localparam int COUNT_W   = $clog2(CAPACITY + 1);
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = SQ_W + 2;
   localparam int HALF_UNIT = 8;                       // one half in 1/16 units
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

   typedef enum logic [1:0] {
      CMD_ADD       = 2'd0,
      CMD_CLOSEST   = 2'd1,
      CMD_MATCH_XY  = 2'd2,
      CMD_MATCH_XYZ = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0]  x;
      logic signed [UNIT_W-1:0]  y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } query_type;

   // travels with each table read down the scan pipeline
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [INDEX_W-1:0] index;
   } scan_tag_type;

   typedef struct packed {
      logic               done;
      logic               found;
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  dist_sq;
   } scan_result_type;

endpackage

`default_nettype wire

// ===== rtl/pns_point_ram.sv =====
// ----------------------------------------------------------------------------
// pns_point_ram: point table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_point_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [pns_pkg::INDEX_W-1:0] wr_addr,
   input  pns_pkg::point_type               wr_data,
   input  wire logic                        rd_en,
   input  wire logic [pns_pkg::INDEX_W-1:0] rd_addr,
   output pns_pkg::point_type               rd_data
);
   import pns_pkg::*;

   point_type mem [CAPACITY];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pns_scan_pipe.sv =====
// ----------------------------------------------------------------------------
// pns_scan_pipe: distance and match pipeline with best-candidate tracker
// Takes one table entry per cycle, keeps the first closest or first match.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_scan_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  pns_pkg::query_type             query,
   input  wire logic [pns_pkg::TOL_W-1:0] tolerance,
   input  pns_pkg::scan_tag_type          issue_tag,
   input  pns_pkg::point_type             rd_data,
   output pns_pkg::scan_result_type       result
);
   import pns_pkg::*;

   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W:0] a,
                                                    input logic signed [COORD_W:0] b);
      logic signed [COORD_W:0] d;
      d = a - b;
      abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
   endfunction

   scan_tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [COORD_W-1:0] dx2_ff, dy2_ff;
   logic [COORD_W-1:0] dx2_in, dy2_in, dz2;
   logic               hit2_ff, hit3_ff, hit4_ff, hit2_in;
   logic [SQ_W-1:0]    sqx3_ff, sqy3_ff;
   logic [DIST_W-1:0]  dist4_ff;
   logic               found_ff, found_in;
   logic [INDEX_W-1:0] best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [COORD_W-1:0] tol_ext;
   logic               is_closest;

   assign tol_ext    = COORD_W'(tolerance);
   assign is_closest = (query.cmd == CMD_CLOSEST);

   // stored whole units scaled back to 1/16 units
   always_comb begin
      dx2_in  = abs_diff({query.x[COORD_W-1], query.x},
                         {rd_data.x[UNIT_W-1], rd_data.x, {FRAC_W{1'b0}}});
      dy2_in  = abs_diff({query.y[COORD_W-1], query.y},
                         {rd_data.y[UNIT_W-1], rd_data.y, {FRAC_W{1'b0}}});
      dz2     = abs_diff({query.z[COORD_W-1], query.z},
                         {rd_data.z[COORD_W-1], rd_data.z});
      hit2_in = (dx2_in < tol_ext) && (dy2_in < tol_ext) &&
                ((query.cmd == CMD_MATCH_XY) || (dz2 < tol_ext));
   end

   // tracker: strict less-than keeps the lowest index on ties
   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      if (clear) begin
         found_in     = 1'b0;
         best_idx_in  = '0;
         best_dist_in = '0;
      end else if (tag4_ff.valid) begin
         if (is_closest) begin
            if (!found_ff || (dist4_ff < best_dist_ff)) begin
               found_in     = 1'b1;
               best_idx_in  = tag4_ff.index;
               best_dist_in = dist4_ff;
            end
         end else if (!found_ff && hit4_ff) begin
            found_in    = 1'b1;
            best_idx_in = tag4_ff.index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff  <= '0;
         tag2_ff  <= '0;
         tag3_ff  <= '0;
         tag4_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         tag1_ff  <= issue_tag;
         tag2_ff  <= tag1_ff;
         tag3_ff  <= tag2_ff;
         tag4_ff  <= tag3_ff;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      dx2_ff       <= dx2_in;
      dy2_ff       <= dy2_in;
      hit2_ff      <= hit2_in;
      sqx3_ff      <= SQ_W'(dx2_ff) * SQ_W'(dx2_ff);
      sqy3_ff      <= SQ_W'(dy2_ff) * SQ_W'(dy2_ff);
      hit3_ff      <= hit2_ff;
      dist4_ff     <= DIST_W'(sqx3_ff) + DIST_W'(sqy3_ff);
      hit4_ff      <= hit3_ff;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
   end

   assign result.done    = tag4_ff.valid && tag4_ff.last;
   assign result.found   = found_ff;
   assign result.index   = best_idx_ff;
   assign result.dist_sq = best_dist_ff;

endmodule

`default_nettype wire

// ===== rtl/point_store_nearest_search.sv =====
// ----------------------------------------------------------------------------
// point_store_nearest_search: point table with add, closest and match search
// Stores up to CAPACITY points and answers brute-force nearest and match scans.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Add answers in the next
// cycle and leaves busy low, so adds can follow back to back. Closest and the
// match commands scan every stored point, one table read per cycle, through a
// six-stage pipeline (table read, differences, squares, sum, best update,
// report); busy stays high until the cycle the answer shows. A query on an
// empty table answers in the next cycle. Each answer is on the rsp_ ports
// for exactly one cycle with rsp_valid high; there is no back-pressure, so
// the receiver must take it then. The tolerance register is written with
// csr_write_enable and should only be changed while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module point_store_nearest_search (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_cmd,
   input  wire logic signed [pns_pkg::COORD_W-1:0] req_x_coord,
   input  wire logic signed [pns_pkg::COORD_W-1:0] req_y_coord,
   input  wire logic signed [pns_pkg::COORD_W-1:0] req_z_coord,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic [pns_pkg::INDEX_W-1:0]             rsp_point_index,
   output logic [pns_pkg::DIST_W-1:0]              rsp_dist_squared,
   input  wire logic                               csr_write_enable,
   input  wire logic [pns_pkg::TOL_W-1:0]          csr_write_data
);
   import pns_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   // round half up to whole units, clamp to the stored range
   function automatic logic signed [UNIT_W-1:0] round_unit(
      input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] t;
      logic        [UNIT_W:0]  q;
      t = {v[COORD_W-1], v} + (COORD_W+1)'(HALF_UNIT);
      q = t[COORD_W:FRAC_W];
      if (!q[UNIT_W] && q[UNIT_W-1]) begin
         round_unit = {1'b0, {(UNIT_W-1){1'b1}}};
      end else if (q[UNIT_W] && !q[UNIT_W-1]) begin
         round_unit = {1'b1, {(UNIT_W-1){1'b0}}};
      end else begin
         round_unit = q[UNIT_W-1:0];
      end
   endfunction

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TOL_W-1:0]   tol_ff;
   query_type          query_ff, query_in;
   logic               issue_ff, issue_in;
   logic [INDEX_W-1:0] addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   logic               accept;
   logic               table_full;
   logic               issue_last;
   logic               scan_clear;
   logic               wr_en;
   cmd_type            req_cmd_t;
   point_type          wr_data;
   point_type          rd_data;
   scan_tag_type       issue_tag;
   scan_result_type    scan_result;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign req_cmd_t  = cmd_type'(req_cmd);
   assign table_full = (count_ff == COUNT_W'(CAPACITY));
   assign wr_en      = accept && (req_cmd_t == CMD_ADD) && !table_full;
   assign scan_clear = accept && (req_cmd_t != CMD_ADD) && (count_ff != '0);

   assign wr_data.x = round_unit(req_x_coord);
   assign wr_data.y = round_unit(req_y_coord);
   assign wr_data.z = req_z_coord;

   // last stored entry ends the read sweep
   assign issue_last      = ({1'b0, addr_ff} == (count_ff - 1'b1));
   assign issue_tag.valid = issue_ff;
   assign issue_tag.last  = issue_last;
   assign issue_tag.index = addr_ff;

   pns_point_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[INDEX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   pns_scan_pipe u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .query     (query_ff),
      .tolerance (tol_ff),
      .issue_tag (issue_tag),
      .rd_data   (rd_data),
      .result    (scan_result)
   );

   // control: add answers at once, queries sweep the table
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      query_in      = query_ff;
      issue_in      = issue_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_dist_in   = rsp_dist_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd_t == CMD_ADD) begin
                  rsp_valid_in = 1'b1;
                  rsp_dist_in  = '0;
                  if (table_full) begin
                     rsp_status_in = STATUS_FULL;
                     rsp_index_in  = '0;
                  end else begin
                     rsp_status_in = STATUS_OK;
                     rsp_index_in  = count_ff[INDEX_W-1:0];
                     count_in      = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NONE;
                  rsp_index_in  = '0;
                  rsp_dist_in   = '0;
               end else begin
                  query_in.cmd = req_cmd_t;
                  query_in.x   = req_x_coord;
                  query_in.y   = req_y_coord;
                  query_in.z   = req_z_coord;
                  issue_in     = 1'b1;
                  addr_in      = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               addr_in = addr_ff + 1'b1;
               if (issue_last) begin
                  issue_in = 1'b0;
               end
            end
            if (scan_result.done) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            rsp_valid_in = 1'b1;
            if (scan_result.found) begin
               rsp_status_in = STATUS_OK;
               rsp_index_in  = scan_result.index;
               rsp_dist_in   = (query_ff.cmd == CMD_CLOSEST) ? scan_result.dist_sq : '0;
            end else begin
               rsp_status_in = STATUS_NONE;
               rsp_index_in  = '0;
               rsp_dist_in   = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            issue_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tol_ff       <= TOL_RESET;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_point_index  = rsp_index_ff;
   assign rsp_dist_squared = rsp_dist_ff;

endmodule

`default_nettype wire

// ===== tb/tb_point_store_nearest_search.sv =====
// ----------------------------------------------------------------------------
// tb_point_store_nearest_search: self-checking bench for the point table
// A directed table, then random requests under several match windows. Every
// answer is checked field by field against a typed answer or against an
// in-bench model of the table kept in step with each request.
// ----------------------------------------------------------------------------
module tb_point_store_nearest_search;
   import pns_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_REQUESTS = 30;
   localparam longint UNIT_MAX = (longint'(1) <<< (UNIT_W - 1)) - 1;
   localparam longint UNIT_MIN = -(longint'(1) <<< (UNIT_W - 1));
   localparam logic signed [COORD_W-1:0] C_MAX = 28'sh7FFFFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 28'sh8000000;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  dist_sq;
   } answer_type;

   typedef enum logic {ROW_REQUEST, ROW_TOLERANCE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      cmd_type                   cmd;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [TOL_W-1:0]          tolerance;
      logic                      typed;
      answer_type                answer;
   } directed_row_type;

   localparam answer_type UNTYPED = '{STATUS_OK, 12'd0, 58'd0};
   localparam answer_type NONE_ANSWER = '{STATUS_NONE, 12'd0, 58'd0};
   localparam int DIRECTED_COUNT = 23;

   // directed table: typed answers only where they are obvious, the rest
   // goes through the model
   localparam directed_row_type DIRECTED [DIRECTED_COUNT] = '{
      // queries on an empty table
      '{ROW_REQUEST, CMD_CLOSEST, 28'sd0, 28'sd0, 28'sd0, 16'd0, 1'b1, NONE_ANSWER},
      '{ROW_REQUEST, CMD_MATCH_XY, 28'sd0, 28'sd0, 28'sd0, 16'd0, 1'b1, NONE_ANSWER},
      '{ROW_REQUEST, CMD_MATCH_XYZ, 28'sd0, 28'sd0, 28'sd0, 16'd0, 1'b1, NONE_ANSWER},
      // rounding half up, saturation at both ends, negative rounding
      '{ROW_REQUEST, CMD_ADD, 28'sd8, -28'sd8, 28'sd5, 16'd0, 1'b1,
        '{STATUS_OK, 12'd0, 58'd0}},
      '{ROW_REQUEST, CMD_ADD, C_MAX, C_MIN, C_MAX, 16'd0, 1'b1,
        '{STATUS_OK, 12'd1, 58'd0}},
      '{ROW_REQUEST, CMD_ADD, C_MIN, C_MAX, C_MIN, 16'd0, 1'b1,
        '{STATUS_OK, 12'd2, 58'd0}},
      '{ROW_REQUEST, CMD_ADD, -28'sd9, 28'sd23, -28'sd1, 16'd0, 1'b1,
        '{STATUS_OK, 12'd3, 58'd0}},
      // duplicate of point 0: ties go to the lowest index
      '{ROW_REQUEST, CMD_ADD, 28'sd16, 28'sd0, 28'sd5, 16'd0, 1'b1,
        '{STATUS_OK, 12'd4, 58'd0}},
      '{ROW_REQUEST, CMD_CLOSEST, 28'sd16, 28'sd0, 28'sd0, 16'd0, 1'b1,
        '{STATUS_OK, 12'd0, 58'd0}},
      // window edges at the reset tolerance
      '{ROW_REQUEST, CMD_MATCH_XY, 28'sd31, 28'sd15, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_MATCH_XY, 28'sd32, 28'sd0, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_MATCH_XYZ, 28'sd16, 28'sd0, 28'sd20, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_MATCH_XYZ, 28'sd16, 28'sd0, 28'sd21, 16'd0, 1'b0, UNTYPED},
      // far corners: every point is a candidate however far
      '{ROW_REQUEST, CMD_CLOSEST, C_MAX, C_MIN, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_CLOSEST, C_MIN, C_MAX, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_CLOSEST, C_MAX, C_MAX, C_MAX, 16'd0, 1'b0, UNTYPED},
      // zero window never matches
      '{ROW_TOLERANCE, CMD_ADD, 28'sd0, 28'sd0, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_MATCH_XY, 28'sd16, 28'sd0, 28'sd0, 16'd0, 1'b1, NONE_ANSWER},
      '{ROW_REQUEST, CMD_MATCH_XYZ, 28'sd16, 28'sd0, 28'sd5, 16'd0, 1'b1, NONE_ANSWER},
      // widest window
      '{ROW_TOLERANCE, CMD_ADD, 28'sd0, 28'sd0, 28'sd0, 16'hFFFF, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_MATCH_XY, C_MAX, C_MAX, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_MATCH_XYZ, 28'sd0, 28'sd0, 28'sd0, 16'd0, 1'b0, UNTYPED},
      '{ROW_REQUEST, CMD_CLOSEST, -28'sd8, 28'sd8, 28'sd0, 16'd0, 1'b0, UNTYPED}
   };

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_cmd = 2'd0;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic signed [COORD_W-1:0] req_z_coord = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [INDEX_W-1:0]        rsp_point_index;
   logic [DIST_W-1:0]         rsp_dist_squared;
   logic                      csr_write_enable = 1'b0;
   logic [TOL_W-1:0]          csr_write_data = '0;

   // bench copy of the point table and the match window
   logic signed [UNIT_W-1:0]  x_units [CAPACITY];
   logic signed [UNIT_W-1:0]  y_units [CAPACITY];
   logic signed [COORD_W-1:0] z_fixed [CAPACITY];
   int                        stored_count = 0;
   logic [TOL_W-1:0]          tolerance_shadow = TOL_RESET;

   answer_type awaited_answers [$];
   int         error_count = 0;
   int         cycle_count = 0;
   logic       idling_on = 1'b1;

   point_store_nearest_search uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_point_index  (rsp_point_index),
      .rsp_dist_squared (rsp_dist_squared),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // table model
   // ---------------------------------------------------------------------

   // round half up to whole units, clamp to the stored range
   function automatic logic signed [UNIT_W-1:0] to_unit(input logic signed [COORD_W-1:0] v);
      longint q;
      q = (longint'(v) + HALF_UNIT) >>> FRAC_W;
      if (q > UNIT_MAX) q = UNIT_MAX;
      if (q < UNIT_MIN) q = UNIT_MIN;
      return q[UNIT_W-1:0];
   endfunction

   function automatic longint unsigned magnitude(input longint d);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic in_window(input longint a, input longint b);
      return magnitude(a - b) < longint'(tolerance_shadow);
   endfunction

   // applies one request to the bench table and returns its answer
   function automatic void point_table_answer(input cmd_type cmd,
         input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
         input logic signed [COORD_W-1:0] z, output answer_type ans);
      longint unsigned dx, dy, d, best;
      logic found;
      int i;
      ans = NONE_ANSWER;
      found = 1'b0;
      best = 0;
      case (cmd)
         CMD_ADD: begin
            if (stored_count >= CAPACITY) begin
               ans.status = STATUS_FULL;
            end else begin
               x_units[stored_count] = to_unit(x);
               y_units[stored_count] = to_unit(y);
               z_fixed[stored_count] = z;
               ans.status = STATUS_OK;
               ans.index = stored_count[INDEX_W-1:0];
               stored_count++;
            end
         end
         CMD_CLOSEST: begin
            // strict less-than keeps the first of equal distances
            for (i = 0; i < stored_count; i++) begin
               dx = magnitude(longint'(x) - longint'(x_units[i]) * 16);
               dy = magnitude(longint'(y) - longint'(y_units[i]) * 16);
               d = dx * dx + dy * dy;
               if (!found || d < best) begin
                  found = 1'b1;
                  best = d;
                  ans.index = i[INDEX_W-1:0];
               end
            end
            if (found) begin
               ans.status = STATUS_OK;
               ans.dist_sq = best[DIST_W-1:0];
            end
         end
         default: begin
            for (i = 0; i < stored_count && !found; i++) begin
               if (in_window(longint'(x_units[i]) * 16, longint'(x)) &&
                   in_window(longint'(y_units[i]) * 16, longint'(y)) &&
                   (cmd == CMD_MATCH_XY || in_window(longint'(z_fixed[i]), longint'(z))))
               begin
                  found = 1'b1;
                  ans.status = STATUS_OK;
                  ans.index = i[INDEX_W-1:0];
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // mostly a modest spread, sometimes the full field or an extreme
   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: return COORD_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return C_MAX;
               1: return C_MIN;
               2: return '0;
               default: return -28'sd8;
            endcase
         end
         default: return COORD_W'(int'($urandom_range(0, 8000)) - 4000);
      endcase
   endfunction

   // a coordinate just inside or just outside the window around base
   function automatic logic signed [COORD_W-1:0] near_coord(input longint base,
         input int spread);
      return COORD_W'(base + longint'(int'($urandom_range(0, 2 * spread)) - spread));
   endfunction

   // start stays high from one request to the next unless an idle gap is drawn,
   // so each time step sees at most one assignment to it
   task automatic issue_request(input cmd_type cmd, input logic signed [COORD_W-1:0] x,
         input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z,
         input logic typed, input answer_type typed_answer);
      answer_type predicted;
      if (idling_on && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      // busy here is the value before the edge: low means the request was taken
      @(posedge clock);
      while (busy) @(posedge clock);
      point_table_answer(cmd, x, y, z, predicted);
      awaited_answers.push_back(typed ? typed_answer : predicted);
   endtask

   // hold off new requests until every answer is in and the block is idle
   task automatic drain_answers();
      start <= 1'b0;
      while (awaited_answers.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      drain_answers();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance_shadow = value;
   endtask

   // about a third adds; queries half the time aimed near a stored point
   task automatic random_request();
      cmd_type cmd;
      int pick;
      int spread;
      logic signed [COORD_W-1:0] x, y, z;
      spread = int'(tolerance_shadow) + 3;
      x = random_coord();
      y = random_coord();
      z = random_coord();
      if (stored_count == 0 || $urandom_range(0, 99) < 35) begin
         cmd = CMD_ADD;
      end else begin
         cmd = cmd_type'($urandom_range(1, 3));
         if ($urandom_range(0, 1) == 1) begin
            pick = $urandom_range(0, stored_count - 1);
            x = near_coord(longint'(x_units[pick]) * 16, spread);
            y = near_coord(longint'(y_units[pick]) * 16, spread);
            z = near_coord(longint'(z_fixed[pick]), spread);
         end
      end
      issue_request(cmd, x, y, z, 1'b0, UNTYPED);
   endtask

   initial begin
      int r;
      int phase;
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED[r].kind == ROW_TOLERANCE)
            write_tolerance(DIRECTED[r].tolerance);
         else
            issue_request(DIRECTED[r].cmd, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z,
                          DIRECTED[r].typed, DIRECTED[r].answer);
      end

      // random phases, each under its own match window; the third runs
      // without idle gaps
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: write_tolerance(TOL_W'($urandom_range(1, 64)));
            1: write_tolerance(16'hFFFF);
            2: write_tolerance(TOL_W'($urandom_range(0, 65535)));
            default: write_tolerance(TOL_W'($urandom_range(8, 200)));
         endcase
         idling_on = (phase != 2);
         for (k = 0; k < PHASE_REQUESTS; k++) begin
            if (phase == 1 && k == PHASE_REQUESTS / 2) drain_answers();
            random_request();
         end
      end

      drain_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("point_store_nearest_search verification clean");
      else
         $display("point_store_nearest_search verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // answer checking: every strobed answer against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: answer with none awaited, status %0d index %0d dist %0d",
                     $time, rsp_status, rsp_point_index, rsp_dist_squared);
            error_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_point_index !== want.index) begin
               $display("%0t: point_index expected %0d actual %0d", $time, want.index,
                        rsp_point_index);
               error_count++;
            end
            if (rsp_dist_squared !== want.dist_sq) begin
               $display("%0t: dist_squared expected %0d actual %0d", $time, want.dist_sq,
                        rsp_dist_squared);
               error_count++;
            end
         end
      end
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("point_store_nearest_search verification failed");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
rtl/pns_pkg.sv
rtl/pns_point_ram.sv
rtl/pns_scan_pipe.sv
rtl/point_store_nearest_search.sv
tb/tb_point_store_nearest_search.sv
